### hdl/khcm_pkg.sv
package khcm_pkg;

  // Default sizes handed to the top level
  localparam int unsigned KeySlotsDef = 6;
  localparam int unsigned TickBitsDef = 16;

  // Widths fixed by the register map and the item fields
  localparam int unsigned CfgTickW  = 16;
  localparam int unsigned LevelW    = 4;
  localparam int unsigned HueW      = 9;
  localparam int unsigned LogW      = 2;
  localparam int unsigned KeyW      = 8;
  localparam int unsigned OutDataW  = 32;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 32;

  // HID usage codes of the command keys
  localparam logic [7:0] KeyB       = 8'h05;
  localparam logic [7:0] KeyD       = 8'h07;
  localparam logic [7:0] KeyF       = 8'h09;
  localparam logic [7:0] KeyL       = 8'h0F;
  localparam logic [7:0] KeyS       = 8'h16;
  localparam logic [7:0] Key1       = 8'h1E;
  localparam logic [7:0] Key2       = 8'h1F;
  localparam logic [7:0] Key3       = 8'h20;
  localparam logic [7:0] KeyMinus   = 8'h2D;
  localparam logic [7:0] KeyEqual   = 8'h2E;
  localparam logic [7:0] KeyKpMinus = 8'h56;
  localparam logic [7:0] KeyKpPlus  = 8'h57;

  localparam logic [LevelW-1:0] MaxLevel = 4'd10;
  localparam logic [HueW-1:0]   HueStep  = 9'd6;
  localparam logic [HueW-1:0]   HueWrap  = 9'd360;

  // Register reset values
  localparam logic [CfgTickW-1:0] HoldTicksRst    = 16'd3000;
  localparam logic [CfgTickW-1:0] IdleTimeoutRst  = 16'd3000;
  localparam logic [CfgTickW-1:0] BlinkPeriodRst  = 16'd100;
  localparam logic [CfgTickW-1:0] RainbowPerRst   = 16'd50;
  localparam logic [7:0]          ChordMaskRst    = 8'h22;
  localparam logic [LevelW-1:0]   StartBrightRst  = 4'd5;
  localparam logic [LogW-1:0]     LogChoiceRst    = 2'd1;

  typedef enum logic [2:0] {
    RegHoldTicks    = 3'd0,
    RegIdleTimeout  = 3'd1,
    RegBlinkPeriod  = 3'd2,
    RegRainbowPer   = 3'd3,
    RegChordMask    = 3'd4,
    RegLedsFitted   = 3'd5,
    RegShiftMapAvl  = 3'd6,
    RegStartBright  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ModeIdle      = 3'd0,
    ModeHoldWait  = 3'd1,
    ModeCommand   = 3'd2,
    ModeLogSel    = 3'd3,
    ModeBrightSel = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    ActNone         = 4'd0,
    ActEmptyReport  = 4'd1,
    ActBootloader   = 4'd2,
    ActFactoryReset = 4'd3,
    ActLogSet       = 4'd4,
    ActOverrideSet  = 4'd5,
    ActOverrideNa   = 4'd6,
    ActBrightSet    = 4'd7,
    ActBrightSave   = 4'd8
  } action_e;

  typedef enum logic [1:0] {
    LogError = 2'd0,
    LogInfo  = 2'd1,
    LogDebug = 2'd2
  } log_e;

endpackage

### hdl/keyboard_hotkey_command_mode_fsm_unit.sv
// Hotkey command-mode controller for a keyboard stream. Each input transaction is either
// a keyboard report (tuser = 0) or a one-millisecond tick (tuser = 1), and each one gives
// exactly one result transaction carrying the forward/suppress decision, the mode, an
// action code and the LED and settings state after that item. The block takes one
// transaction per clock cycle while the downstream side does not stall; an accepted item
// is held in the input register, and its result is then registered into the result
// register and offered from there. The rate is set by the result register: when the
// downstream side stalls, the input register holds one further item and then input ready
// drops. The user must write configuration over the APB port only while no item is in
// flight; the block itself does not enforce this.
module keyboard_hotkey_command_mode_fsm_unit #(
  parameter int unsigned KEY_SLOTS = khcm_pkg::KeySlotsDef,
  parameter int unsigned TICK_BITS = khcm_pkg::TickBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // modifier_bits, key_slot_0, key_slot_1, ... (8 bits each)
  input  logic [8*(KEY_SLOTS+1)-1:0]     s_axis_tdata,
  // func
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pass_report, mode, action, log_level, shift_override, brightness, led_green, hue,
  // led_update, zero padding
  output logic [khcm_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [khcm_pkg::ApbAddrW-1:0]  paddr,
  input  logic [khcm_pkg::ApbDataW-1:0]  pwdata,
  output logic [khcm_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  localparam int unsigned InW = 8 * (KEY_SLOTS + 1);
  localparam int unsigned CmpW = (TICK_BITS > khcm_pkg::CfgTickW) ? TICK_BITS
                                                                    : khcm_pkg::CfgTickW;

  // Configuration registers
  logic [khcm_pkg::CfgTickW-1:0] hold_ticks_q, idle_timeout_q, blink_period_q, rainbow_per_q;
  logic [7:0]                    chord_mask_q;
  logic                          leds_fitted_q, shift_map_q;
  logic [khcm_pkg::LevelW-1:0]   start_bright_q;

  // Controller state
  khcm_pkg::mode_e               mode_q, mode_d;
  logic [TICK_BITS-1:0]          elapsed_q, elapsed_d, blink_q, blink_d;
  logic                          green_q, green_d;
  logic [khcm_pkg::HueW-1:0]     hue_q, hue_d;
  logic [khcm_pkg::LevelW-1:0]   level_q, level_d, entry_level_q, entry_level_d;
  logic                          override_q, override_d;
  logic [khcm_pkg::LogW-1:0]     log_q, log_d;

  // Pipeline registers
  logic                          in_valid_q;
  logic [InW-1:0]                in_data_q;
  logic                          in_func_q;
  logic                          out_valid_q;
  logic [khcm_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic                          advance, in_take, cfg_wr;
  khcm_pkg::action_e             action;
  logic                          pass_report;
  logic [TICK_BITS-1:0]          elapsed_inc, blink_inc;
  logic [khcm_pkg::HueW-1:0]     hue_next;
  logic [khcm_pkg::LevelW-1:0]   start_clamped;
  logic                          hit_b, hit_d, hit_f, hit_l, hit_s, hit_1, hit_2, hit_3;
  logic                          hit_up, hit_down, slots_empty, chord_clean;
  logic [7:0]                    slot;

  // Handshake: the input register moves on when the result register is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign start_clamped = (pwdata[khcm_pkg::LevelW-1:0] > khcm_pkg::MaxLevel)
                         ? khcm_pkg::MaxLevel : pwdata[khcm_pkg::LevelW-1:0];

  always_comb begin
    prdata = '0;
    case (khcm_pkg::reg_idx_e'(paddr[4:2]))
      khcm_pkg::RegHoldTicks:   prdata = khcm_pkg::ApbDataW'(hold_ticks_q);
      khcm_pkg::RegIdleTimeout: prdata = khcm_pkg::ApbDataW'(idle_timeout_q);
      khcm_pkg::RegBlinkPeriod: prdata = khcm_pkg::ApbDataW'(blink_period_q);
      khcm_pkg::RegRainbowPer:  prdata = khcm_pkg::ApbDataW'(rainbow_per_q);
      khcm_pkg::RegChordMask:   prdata = khcm_pkg::ApbDataW'(chord_mask_q);
      khcm_pkg::RegLedsFitted:  prdata = khcm_pkg::ApbDataW'(leds_fitted_q);
      khcm_pkg::RegShiftMapAvl: prdata = khcm_pkg::ApbDataW'(shift_map_q);
      khcm_pkg::RegStartBright: prdata = khcm_pkg::ApbDataW'(start_bright_q);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q   <= khcm_pkg::HoldTicksRst;
      idle_timeout_q <= khcm_pkg::IdleTimeoutRst;
      blink_period_q <= khcm_pkg::BlinkPeriodRst;
      rainbow_per_q  <= khcm_pkg::RainbowPerRst;
      chord_mask_q   <= khcm_pkg::ChordMaskRst;
      leds_fitted_q  <= 1'b1;
      shift_map_q    <= 1'b1;
      start_bright_q <= khcm_pkg::StartBrightRst;
    end else if (cfg_wr) begin
      case (khcm_pkg::reg_idx_e'(paddr[4:2]))
        khcm_pkg::RegHoldTicks:   hold_ticks_q   <= pwdata[khcm_pkg::CfgTickW-1:0];
        khcm_pkg::RegIdleTimeout: idle_timeout_q <= pwdata[khcm_pkg::CfgTickW-1:0];
        khcm_pkg::RegBlinkPeriod: blink_period_q <= pwdata[khcm_pkg::CfgTickW-1:0];
        khcm_pkg::RegRainbowPer:  rainbow_per_q  <= pwdata[khcm_pkg::CfgTickW-1:0];
        khcm_pkg::RegChordMask:   chord_mask_q   <= pwdata[7:0];
        khcm_pkg::RegLedsFitted:  leds_fitted_q  <= pwdata[0];
        khcm_pkg::RegShiftMapAvl: shift_map_q    <= pwdata[0];
        khcm_pkg::RegStartBright: start_bright_q <= pwdata[khcm_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Key slot decode
  always_comb begin
    hit_b = 1'b0; hit_d = 1'b0; hit_f = 1'b0; hit_l = 1'b0; hit_s = 1'b0;
    hit_1 = 1'b0; hit_2 = 1'b0; hit_3 = 1'b0; hit_up = 1'b0; hit_down = 1'b0;
    slots_empty = 1'b1;
    slot = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      slot = in_data_q[8*i+8 +: 8];
      hit_b    = hit_b    || (slot == khcm_pkg::KeyB);
      hit_d    = hit_d    || (slot == khcm_pkg::KeyD);
      hit_f    = hit_f    || (slot == khcm_pkg::KeyF);
      hit_l    = hit_l    || (slot == khcm_pkg::KeyL);
      hit_s    = hit_s    || (slot == khcm_pkg::KeyS);
      hit_1    = hit_1    || (slot == khcm_pkg::Key1);
      hit_2    = hit_2    || (slot == khcm_pkg::Key2);
      hit_3    = hit_3    || (slot == khcm_pkg::Key3);
      hit_up   = hit_up   || (slot == khcm_pkg::KeyEqual) || (slot == khcm_pkg::KeyKpPlus);
      hit_down = hit_down || (slot == khcm_pkg::KeyMinus) || (slot == khcm_pkg::KeyKpMinus);
      slots_empty = slots_empty && (slot == '0);
    end
  end

  assign chord_clean = (in_data_q[7:0] == chord_mask_q) && slots_empty;

  // Both counters saturate rather than wrap.
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign blink_inc   = (blink_q == '1) ? blink_q : blink_q + 1'b1;
  assign hue_next    = (hue_q + khcm_pkg::HueStep >= khcm_pkg::HueWrap)
                       ? hue_q + khcm_pkg::HueStep - khcm_pkg::HueWrap
                       : hue_q + khcm_pkg::HueStep;

  always_comb begin
    mode_d        = mode_q;
    elapsed_d     = elapsed_q;
    blink_d       = blink_q;
    green_d       = green_q;
    hue_d         = hue_q;
    level_d       = level_q;
    entry_level_d = entry_level_q;
    override_d    = override_q;
    log_d         = log_q;
    action        = khcm_pkg::ActNone;
    pass_report   = 1'b0;

    if (in_func_q) begin
      if (mode_q != khcm_pkg::ModeIdle) begin
        elapsed_d = elapsed_inc;
        blink_d   = blink_inc;
        if (mode_q == khcm_pkg::ModeHoldWait) begin
          if (CmpW'(elapsed_inc) >= CmpW'(hold_ticks_q)) begin
            mode_d    = khcm_pkg::ModeCommand;
            elapsed_d = '0;
            blink_d   = '0;
            if (leds_fitted_q) begin
              green_d = 1'b1;
            end
            action = khcm_pkg::ActEmptyReport;
          end
        end else if (CmpW'(elapsed_inc) >= CmpW'(idle_timeout_q)) begin
          if (mode_q == khcm_pkg::ModeBrightSel && level_q != entry_level_q) begin
            action = khcm_pkg::ActBrightSave;
          end
          mode_d = khcm_pkg::ModeIdle;
        end else if (leds_fitted_q) begin
          if (mode_q == khcm_pkg::ModeBrightSel) begin
            if (CmpW'(blink_inc) >= CmpW'(rainbow_per_q)) begin
              hue_d   = hue_next;
              blink_d = '0;
            end
          end else if (CmpW'(blink_inc) >= CmpW'(blink_period_q)) begin
            green_d = !green_q;
            blink_d = '0;
          end
        end
      end
    end else begin
      case (mode_q)
        khcm_pkg::ModeIdle: begin
          pass_report = 1'b1;
          if (chord_clean) begin
            mode_d    = khcm_pkg::ModeHoldWait;
            elapsed_d = '0;
          end
        end
        khcm_pkg::ModeHoldWait: begin
          pass_report = 1'b1;
          if (!chord_clean) begin
            mode_d = khcm_pkg::ModeIdle;
          end
        end
        khcm_pkg::ModeCommand: begin
          if (hit_b) begin
            mode_d = khcm_pkg::ModeIdle;
            action = khcm_pkg::ActBootloader;
          end else if (hit_d) begin
            mode_d    = khcm_pkg::ModeLogSel;
            elapsed_d = '0;
          end else if (hit_f) begin
            mode_d = khcm_pkg::ModeIdle;
            action = khcm_pkg::ActFactoryReset;
          end else if (hit_l) begin
            // Without LEDs the key is swallowed and command mode stays.
            if (leds_fitted_q) begin
              mode_d        = khcm_pkg::ModeBrightSel;
              elapsed_d     = '0;
              entry_level_d = level_q;
              hue_d         = '0;
            end
          end else if (hit_s) begin
            mode_d = khcm_pkg::ModeIdle;
            if (shift_map_q) begin
              override_d = !override_q;
              action     = khcm_pkg::ActOverrideSet;
            end else begin
              action = khcm_pkg::ActOverrideNa;
            end
          end
        end
        khcm_pkg::ModeLogSel: begin
          if (hit_1 || hit_2 || hit_3) begin
            mode_d = khcm_pkg::ModeIdle;
            action = khcm_pkg::ActLogSet;
            if (hit_1) begin
              log_d = khcm_pkg::LogError;
            end else if (hit_2) begin
              log_d = khcm_pkg::LogInfo;
            end else begin
              log_d = khcm_pkg::LogDebug;
            end
          end
        end
        khcm_pkg::ModeBrightSel: begin
          if (hit_up) begin
            if (level_q < khcm_pkg::MaxLevel) begin
              level_d   = level_q + 1'b1;
              elapsed_d = '0;
              action    = khcm_pkg::ActBrightSet;
            end
          end else if (hit_down && level_q != '0) begin
            level_d   = level_q - 1'b1;
            elapsed_d = '0;
            action    = khcm_pkg::ActBrightSet;
          end
        end
        default: begin
          mode_d = khcm_pkg::ModeIdle;
        end
      endcase
    end
  end

  always_comb begin
    out_data_d        = '0;
    out_data_d[0]     = pass_report;
    out_data_d[3:1]   = mode_d;
    out_data_d[7:4]   = action;
    out_data_d[9:8]   = log_d;
    out_data_d[10]    = override_d;
    out_data_d[14:11] = level_d;
    out_data_d[15]    = green_d;
    out_data_d[24:16] = hue_d;
    out_data_d[25]    = (green_d != green_q) || (hue_d != hue_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= khcm_pkg::ModeIdle;
      elapsed_q     <= '0;
      blink_q       <= '0;
      green_q       <= 1'b0;
      hue_q         <= '0;
      level_q       <= khcm_pkg::StartBrightRst;
      entry_level_q <= '0;
      override_q    <= 1'b0;
      log_q         <= khcm_pkg::LogChoiceRst;
    end else begin
      if (advance) begin
        mode_q        <= mode_d;
        elapsed_q     <= elapsed_d;
        blink_q       <= blink_d;
        green_q       <= green_d;
        hue_q         <= hue_d;
        entry_level_q <= entry_level_d;
        override_q    <= override_d;
        log_q         <= log_d;
      end
      // A brightness preset written over APB loads the live level, clamped to the maximum.
      if (cfg_wr && khcm_pkg::reg_idx_e'(paddr[4:2]) == khcm_pkg::RegStartBright) begin
        level_q <= start_clamped;
      end else if (advance) begin
        level_q <= level_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
      in_func_q <= s_axis_tuser;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

### dv/testbench.sv
module testbench;

  localparam int unsigned RingDepth   = 256;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldOffLen  = 300;

  // One input transaction: func in tuser, modifier byte and key slots in tdata.
  typedef struct packed {
    logic        func;
    logic [55:0] data;
  } kb_item_t;

  // Result word, last member in the lowest bits.
  typedef struct packed {
    logic [5:0]        pad;
    logic              led_update;
    logic [8:0]        hue;
    logic              led_green;
    logic [3:0]        brightness;
    logic              shift_override;
    khcm_pkg::log_e    log_level;
    khcm_pkg::action_e action;
    khcm_pkg::mode_e   mode;
    logic              pass_report;
  } hk_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // modifier_bits, key_slot_0 .. key_slot_5 (8 bits each)
  logic [55:0] s_axis_tdata  = '0;
  // func
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // pass_report, mode, action, log_level, shift_override, brightness, led_green, hue,
  // led_update, zero padding
  logic [31:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  always #1 clk_i = ~clk_i;

  keyboard_hotkey_command_mode_fsm_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow registers and shadow state of the controller.
  logic [15:0] c_hold, c_idle, c_blink, c_rainbow;
  logic [7:0]  c_chord;
  logic        c_leds, c_shiftmap;
  logic [3:0]  c_start;

  khcm_pkg::mode_e m_mode;
  logic [15:0]     m_elapsed, m_blink;
  logic            m_green;
  logic [8:0]      m_hue;
  logic [3:0]      m_level, m_level_entry;
  logic            m_override;
  khcm_pkg::log_e  m_log;

  kb_item_t    pending_items [$];
  hk_result_t  expected_results [RingDepth];
  int unsigned results_written = 0;
  int unsigned results_checked = 0;
  int unsigned errors          = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_off_left   = 0;
  int unsigned quiet_cycles    = 0;

  task automatic reset_shadow();
    c_hold = khcm_pkg::HoldTicksRst;  c_idle = khcm_pkg::IdleTimeoutRst;
    c_blink = khcm_pkg::BlinkPeriodRst; c_rainbow = khcm_pkg::RainbowPerRst;
    c_chord = khcm_pkg::ChordMaskRst; c_leds = 1'b1; c_shiftmap = 1'b1;
    c_start = khcm_pkg::StartBrightRst;
    m_mode = khcm_pkg::ModeIdle; m_elapsed = '0; m_blink = '0; m_green = 1'b0; m_hue = '0;
    m_level = khcm_pkg::StartBrightRst; m_level_entry = '0; m_override = 1'b0;
    m_log = khcm_pkg::LogInfo;
  endtask

  function automatic logic [15:0] sat_inc(logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic bit has_key(logic [55:0] d, logic [7:0] code);
    for (int i = 1; i <= 6; i++)
      if (d[8*i +: 8] == code) return 1'b1;
    return 1'b0;
  endfunction

  function automatic hk_result_t predict_hotkey(kb_item_t it);
    hk_result_t r;
    logic       g0;
    logic [8:0] h0;
    bit         clean;
    r = '0;
    g0 = m_green;
    h0 = m_hue;
    r.action = khcm_pkg::ActNone;
    clean = (it.data[7:0] == c_chord) && (it.data[55:8] == '0);
    if (it.func) begin
      if (m_mode != khcm_pkg::ModeIdle) begin
        m_elapsed = sat_inc(m_elapsed);
        m_blink   = sat_inc(m_blink);
        if (m_mode == khcm_pkg::ModeHoldWait) begin
          if (m_elapsed >= c_hold) begin
            m_mode = khcm_pkg::ModeCommand; m_elapsed = '0; m_blink = '0;
            if (c_leds) m_green = 1'b1;
            r.action = khcm_pkg::ActEmptyReport;
          end
        end else if (m_elapsed >= c_idle) begin
          if (m_mode == khcm_pkg::ModeBrightSel && m_level != m_level_entry)
            r.action = khcm_pkg::ActBrightSave;
          m_mode = khcm_pkg::ModeIdle;
        end else if (c_leds) begin
          // Brightness selection steps the hue; the other command states blink.
          if (m_mode == khcm_pkg::ModeBrightSel) begin
            if (m_blink >= c_rainbow) begin
              m_hue = (m_hue + khcm_pkg::HueStep) % khcm_pkg::HueWrap;
              m_blink = '0;
            end
          end else if (m_blink >= c_blink) begin
            m_green = ~m_green;
            m_blink = '0;
          end
        end
      end
    end else begin
      case (m_mode)
        khcm_pkg::ModeIdle: begin
          r.pass_report = 1'b1;
          if (clean) begin
            m_mode = khcm_pkg::ModeHoldWait; m_elapsed = '0;
          end
        end
        khcm_pkg::ModeHoldWait: begin
          r.pass_report = 1'b1;
          if (!clean) m_mode = khcm_pkg::ModeIdle;
        end
        khcm_pkg::ModeCommand: begin
          if (has_key(it.data, khcm_pkg::KeyB)) begin
            m_mode = khcm_pkg::ModeIdle; r.action = khcm_pkg::ActBootloader;
          end else if (has_key(it.data, khcm_pkg::KeyD)) begin
            m_mode = khcm_pkg::ModeLogSel; m_elapsed = '0;
          end else if (has_key(it.data, khcm_pkg::KeyF)) begin
            m_mode = khcm_pkg::ModeIdle; r.action = khcm_pkg::ActFactoryReset;
          end else if (has_key(it.data, khcm_pkg::KeyL)) begin
            if (c_leds) begin
              m_mode = khcm_pkg::ModeBrightSel; m_elapsed = '0;
              m_level_entry = m_level; m_hue = '0;
            end
          end else if (has_key(it.data, khcm_pkg::KeyS)) begin
            m_mode = khcm_pkg::ModeIdle;
            if (!c_shiftmap) begin
              r.action = khcm_pkg::ActOverrideNa;
            end else begin
              m_override = ~m_override;
              r.action = khcm_pkg::ActOverrideSet;
            end
          end
        end
        khcm_pkg::ModeLogSel: begin
          if (has_key(it.data, khcm_pkg::Key1)) begin
            m_log = khcm_pkg::LogError; m_mode = khcm_pkg::ModeIdle;
            r.action = khcm_pkg::ActLogSet;
          end else if (has_key(it.data, khcm_pkg::Key2)) begin
            m_log = khcm_pkg::LogInfo; m_mode = khcm_pkg::ModeIdle;
            r.action = khcm_pkg::ActLogSet;
          end else if (has_key(it.data, khcm_pkg::Key3)) begin
            m_log = khcm_pkg::LogDebug; m_mode = khcm_pkg::ModeIdle;
            r.action = khcm_pkg::ActLogSet;
          end
        end
        khcm_pkg::ModeBrightSel: begin
          if (has_key(it.data, khcm_pkg::KeyEqual) ||
              has_key(it.data, khcm_pkg::KeyKpPlus)) begin
            if (m_level < khcm_pkg::MaxLevel) begin
              m_level = m_level + 4'd1; m_elapsed = '0;
              r.action = khcm_pkg::ActBrightSet;
            end
          end else if (has_key(it.data, khcm_pkg::KeyMinus) ||
                       has_key(it.data, khcm_pkg::KeyKpMinus)) begin
            if (m_level > 4'd0) begin
              m_level = m_level - 4'd1; m_elapsed = '0;
              r.action = khcm_pkg::ActBrightSet;
            end
          end
        end
        default: m_mode = khcm_pkg::ModeIdle;
      endcase
    end
    r.mode           = m_mode;
    r.log_level      = m_log;
    r.shift_override = m_override;
    r.brightness     = m_level;
    r.led_green      = m_green;
    r.hue            = m_hue;
    r.led_update     = (m_green != g0) || (m_hue != h0);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic compare_result(hk_result_t exp_r, hk_result_t got);
    check_field("pass_report", exp_r.pass_report, got.pass_report);
    check_field("mode", exp_r.mode, got.mode);
    check_field("action", exp_r.action, got.action);
    check_field("log_level", exp_r.log_level, got.log_level);
    check_field("shift_override", exp_r.shift_override, got.shift_override);
    check_field("brightness", exp_r.brightness, got.brightness);
    check_field("led_green", exp_r.led_green, got.led_green);
    check_field("hue", exp_r.hue, got.hue);
    check_field("led_update", exp_r.led_update, got.led_update);
    check_field("padding", exp_r.pad, got.pad);
  endtask

  // Input side: prediction happens at the edge where the transaction is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results[results_written % RingDepth] <=
          predict_hotkey({s_axis_tuser, s_axis_tdata});
        results_written <= results_written + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          {s_axis_tuser, s_axis_tdata} <= pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_checked == results_written) begin
          $error("result transaction with no expectation waiting: %h", m_axis_tdata);
          errors++;
        end else begin
          compare_result(expected_results[results_checked % RingDepth],
                         hk_result_t'(m_axis_tdata));
          results_checked <= results_checked + 1;
        end
      end
      if (hold_off_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_off_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(khcm_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      khcm_pkg::RegHoldTicks:   c_hold = val[15:0];
      khcm_pkg::RegIdleTimeout: c_idle = val[15:0];
      khcm_pkg::RegBlinkPeriod: c_blink = val[15:0];
      khcm_pkg::RegRainbowPer:  c_rainbow = val[15:0];
      khcm_pkg::RegChordMask:   c_chord = val[7:0];
      khcm_pkg::RegLedsFitted:  c_leds = val[0];
      khcm_pkg::RegShiftMapAvl: c_shiftmap = val[0];
      khcm_pkg::RegStartBright: begin
        c_start = val[3:0];
        m_level = (val[3:0] > khcm_pkg::MaxLevel) ? khcm_pkg::MaxLevel : val[3:0];
      end
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [15:0] hold, input logic [15:0] idle,
                              input logic [15:0] blink, input logic [15:0] rainbow,
                              input logic [7:0] chord, input logic leds,
                              input logic shiftmap, input logic [3:0] start);
    write_reg(khcm_pkg::RegHoldTicks, {16'd0, hold});
    write_reg(khcm_pkg::RegIdleTimeout, {16'd0, idle});
    write_reg(khcm_pkg::RegBlinkPeriod, {16'd0, blink});
    write_reg(khcm_pkg::RegRainbowPer, {16'd0, rainbow});
    write_reg(khcm_pkg::RegChordMask, {24'd0, chord});
    write_reg(khcm_pkg::RegLedsFitted, {31'd0, leds});
    write_reg(khcm_pkg::RegShiftMapAvl, {31'd0, shiftmap});
    write_reg(khcm_pkg::RegStartBright, {28'd0, start});
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || results_written != results_checked);
  endtask

  function automatic kb_item_t tick_item();
    kb_item_t    it;
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    it.func = 1'b1;
    it.data = junk[55:0];
    return it;
  endfunction

  function automatic kb_item_t noise_report();
    kb_item_t    it;
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    it.func = 1'b0;
    it.data = junk[55:0];
    return it;
  endfunction

  function automatic kb_item_t chord_report();
    kb_item_t it;
    it.func = 1'b0;
    it.data = {48'd0, c_chord};
    return it;
  endfunction

  // Places one key code in a random slot, the other slots empty or random.
  function automatic kb_item_t key_report(logic [7:0] mods, logic [7:0] code, bit noisy);
    kb_item_t    it;
    int unsigned slot;
    slot = $urandom_range(6, 1);
    it.func = 1'b0;
    it.data = '0;
    it.data[7:0] = mods;
    if (noisy)
      for (int i = 1; i <= 6; i++) it.data[8*i +: 8] = 8'($urandom);
    it.data[8*slot +: 8] = code;
    return it;
  endfunction

  task automatic queue_ticks(int unsigned n);
    repeat (n) pending_items.push_back(tick_item());
  endtask

  // Mostly a full hotkey session with random content; some noise and broken holds.
  task automatic queue_session();
    int unsigned r, n, to_ticks;
    logic [7:0]  code;
    r = $urandom_range(99);
    if (r < 12) begin
      repeat ($urandom_range(3, 1)) pending_items.push_back(noise_report());
      queue_ticks($urandom_range(2, 0));
      return;
    end
    if (r < 20) pending_items.push_back(key_report(c_chord, 8'($urandom), 1'b0));
    else        pending_items.push_back(chord_report());
    n = (c_hold > 40) ? 40 : c_hold;
    to_ticks = (c_idle >= 60) ? 60 : c_idle + 1;
    if ($urandom_range(9) == 0) begin
      queue_ticks($urandom_range(n, 0));
      pending_items.push_back(noise_report());
    end
    queue_ticks(n + $urandom_range(1, 0));
    if ($urandom_range(3) == 0) queue_ticks($urandom_range(4, 1));
    r = $urandom_range(99);
    code = (r < 12) ? khcm_pkg::KeyB : (r < 32) ? khcm_pkg::KeyD :
           (r < 44) ? khcm_pkg::KeyF : (r < 72) ? khcm_pkg::KeyL :
           (r < 86) ? khcm_pkg::KeyS : 8'($urandom);
    pending_items.push_back(key_report(8'($urandom), code, $urandom_range(3) == 0));
    if (code == khcm_pkg::KeyD) begin
      queue_ticks($urandom_range(3, 0));
      r = $urandom_range(99);
      code = (r < 30) ? khcm_pkg::Key1 : (r < 60) ? khcm_pkg::Key2 :
             (r < 90) ? khcm_pkg::Key3 : 8'($urandom);
      pending_items.push_back(key_report(8'($urandom), code, $urandom_range(3) == 0));
    end else if (code == khcm_pkg::KeyL) begin
      repeat ($urandom_range(12, 2)) begin
        r = $urandom_range(99);
        if (r >= 85) begin
          queue_ticks($urandom_range(4, 1));
        end else begin
          code = (r < 25) ? khcm_pkg::KeyEqual : (r < 40) ? khcm_pkg::KeyKpPlus :
                 (r < 60) ? khcm_pkg::KeyMinus : (r < 75) ? khcm_pkg::KeyKpMinus :
                 8'($urandom);
          pending_items.push_back(key_report(8'($urandom), code, $urandom_range(4) == 0));
        end
      end
    end
    if ($urandom_range(2) == 0) queue_ticks(to_ticks);
  endtask

  function automatic logic [15:0] pick_ticks(int unsigned lo, int unsigned hi, bit allow_max);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (allow_max && r < 20) return 16'hFFFF;
    return 16'($urandom_range(hi, lo));
  endfunction

  initial begin
    kb_item_t it;
    reset_shadow();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset register values: forwarding in idle and the start of a hold on both shifts.
    pending_items.push_back(noise_report());
    pending_items.push_back(chord_report());
    queue_ticks(3);
    pending_items.push_back(noise_report());
    wait_drained();

    // Every command once, a start level above the limit, a hue wrap and a brightness save.
    apply_config(16'd2, 16'd400, 16'd3, 16'd1, 8'h22, 1'b1, 1'b1, 4'd15);
    it.func = 1'b0;
    it.data = '1;
    pending_items.push_back(it);
    it.data = '0;
    pending_items.push_back(it);
    pending_items.push_back(chord_report());
    queue_ticks(2);
    it.data = '0;
    it.data[15:8]  = khcm_pkg::KeyD;
    it.data[55:48] = khcm_pkg::KeyB;
    pending_items.push_back(it);
    pending_items.push_back(chord_report());
    queue_ticks(2);
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyD, 1'b0));
    queue_ticks(1);
    it.data = '0;
    it.data[55:48] = khcm_pkg::Key3;
    pending_items.push_back(it);
    pending_items.push_back(chord_report());
    queue_ticks(2);
    pending_items.push_back(key_report(8'hFF, khcm_pkg::KeyF, 1'b0));
    pending_items.push_back(chord_report());
    queue_ticks(2);
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyS, 1'b0));
    pending_items.push_back(chord_report());
    queue_ticks(1);
    pending_items.push_back(key_report(8'h22, 8'h04, 1'b0));
    pending_items.push_back(chord_report());
    queue_ticks(7);
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyL, 1'b0));
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyKpPlus, 1'b0));
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyMinus, 1'b0));
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyKpMinus, 1'b0));
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyEqual, 1'b0));
    queue_ticks(401);
    pending_items.push_back(chord_report());
    queue_ticks(2);
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyL, 1'b0));
    wait_drained();

    // LEDs removed while brightness selection is open, no shift map, zero registers apart from the idle timeout.
    apply_config(16'd0, 16'd1, 16'd0, 16'd0, 8'h00, 1'b0, 1'b0, 4'd0);
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyKpMinus, 1'b0));
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyEqual, 1'b0));
    queue_ticks(1);
    pending_items.push_back(chord_report());
    queue_ticks(1);
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyL, 1'b0));
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyS, 1'b0));
    pending_items.push_back(chord_report());
    queue_ticks(1);
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyD, 1'b0));
    pending_items.push_back(key_report(8'h00, khcm_pkg::Key1, 1'b0));
    wait_drained();

    // Largest register values: the hold stays pending until a key breaks it.
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 4'd10);
    pending_items.push_back(chord_report());
    queue_ticks(40);
    pending_items.push_back(key_report(8'h00, khcm_pkg::KeyD, 1'b0));
    queue_ticks(20);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      apply_config(pick_ticks(1, 6, 1'b0), pick_ticks(3, 40, 1'b1), pick_ticks(1, 6, 1'b1),
                   pick_ticks(1, 4, 1'b1), ($urandom_range(1) == 0) ? 8'h22 : 8'($urandom),
                   $urandom_range(3) != 0, 1'($urandom), 4'($urandom));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      while (pending_items.size() < 100) queue_session();
      // A long receiver hold-off while the sender keeps offering fills the block up.
      if (p % 4 == 0) hold_off_left = HoldOffLen;
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
